// File: design/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared field widths, hue constants and the sideband record.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int HUE_BITS  = 11;
   localparam int FRAC_BITS = 8;
   localparam int PORT_BITS = 8;

   localparam logic [HUE_BITS-1:0]  HUE_FULL = 11'd1536;
   localparam logic [FRAC_BITS:0]   FRAC_ONE = 9'd256;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

   typedef struct packed {
      sector_type sector;
      logic       grey;
   } side_type;

endpackage

// File: design/hsv2rgb_prep.sv
// ----------------------------------------------------------------------------
// HSV to RGB front stage
// Wraps hue, splits sector and fraction, forms the p, q and t factors.
// ----------------------------------------------------------------------------
module hsv2rgb_prep #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic [hsv2rgb_pkg::HUE_BITS-1:0]    hue,
   input  logic [hsv2rgb_pkg::PORT_BITS-1:0]   saturation,
   input  logic [hsv2rgb_pkg::PORT_BITS-1:0]   value,
   output hsv2rgb_pkg::side_type               side_ff,
   output logic [CHANNEL_BITS-1:0]             value_ff,
   output logic [CHANNEL_BITS-1:0]             p_factor_ff,
   output logic [CHANNEL_BITS+7:0]             q_factor_ff,
   output logic [CHANNEL_BITS+7:0]             t_factor_ff
);

   localparam int CW = CHANNEL_BITS;
   localparam int KW = CHANNEL_BITS + hsv2rgb_pkg::FRAC_BITS;
   localparam logic [CW-1:0] CH_MAX = CW'((2 ** CHANNEL_BITS) - 1);
   localparam logic [KW-1:0] FULL   = KW'(((2 ** CHANNEL_BITS) - 1) * 256);

   logic [hsv2rgb_pkg::HUE_BITS-1:0]  hue_wrap;
   logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac;
   logic [CW-1:0]                     sat_c;
   hsv2rgb_pkg::side_type             side_in;
   logic [CW-1:0]                     value_in;
   logic [CW-1:0]                     p_factor_in;
   logic [KW-1:0]                     q_factor_in;
   logic [KW-1:0]                     t_factor_in;

   always_comb begin
      hue_wrap = (hue >= hsv2rgb_pkg::HUE_FULL) ? hue - hsv2rgb_pkg::HUE_FULL : hue;
      frac     = hue_wrap[hsv2rgb_pkg::FRAC_BITS-1:0];
      sat_c    = CW'(saturation);
      value_in = CW'(value);
      side_in.sector = hsv2rgb_pkg::sector_type'(
         hue_wrap[hsv2rgb_pkg::HUE_BITS-1:hsv2rgb_pkg::FRAC_BITS]);
      side_in.grey   = (sat_c == '0);
      p_factor_in = CH_MAX - sat_c;
      q_factor_in = FULL - KW'(sat_c) * KW'(frac);
      t_factor_in = FULL - KW'(sat_c) * KW'(hsv2rgb_pkg::FRAC_ONE - {1'b0, frac});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff     <= side_in;
         value_ff    <= value_in;
         p_factor_ff <= p_factor_in;
         q_factor_ff <= q_factor_in;
         t_factor_ff <= t_factor_in;
      end
   end

endmodule

// File: design/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB scaling unit
// value * factor, optional shift right by PRE_SHIFT, then /(2^n - 1) by estimate and correction.
// Three register stages.
// ----------------------------------------------------------------------------
module hsv2rgb_scale #(
   parameter int CHANNEL_BITS = 8,
   parameter int FACTOR_BITS  = 8,
   parameter int PRE_SHIFT    = 0
) (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [CHANNEL_BITS-1:0] value,
   input  logic [FACTOR_BITS-1:0]  factor,
   output logic [CHANNEL_BITS-1:0] quotient_ff
);

   localparam int CW = CHANNEL_BITS;
   localparam int PW = CHANNEL_BITS + FACTOR_BITS;
   localparam int XW = 2 * CHANNEL_BITS;
   localparam int SW = 2 * CHANNEL_BITS + 1;
   localparam logic [XW-1:0] CH_MAX = XW'((2 ** CHANNEL_BITS) - 1);

   logic [PW-1:0] product_in;
   logic [XW-1:0] dividend_in;
   logic [XW-1:0] dividend_ff;
   logic [XW-1:0] dividend_d_ff;
   logic [CW-1:0] estimate_in;
   logic [CW-1:0] estimate_ff;
   logic [XW-1:0] back_in;
   logic [XW-1:0] remainder_in;
   logic [CW-1:0] quotient_in;

   // dividend stays below 2^(2n); estimate is low by at most one
   always_comb begin
      product_in   = PW'(value) * PW'(factor);
      dividend_in  = XW'(product_in >> PRE_SHIFT);
      estimate_in  = CW'((SW'(dividend_ff) + SW'(dividend_ff >> CW)) >> CW);
      back_in      = {estimate_ff, {CW{1'b0}}} - XW'(estimate_ff);
      remainder_in = dividend_d_ff - back_in;
      quotient_in  = (remainder_in >= CH_MAX) ? estimate_ff + CW'(1) : estimate_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dividend_ff   <= dividend_in;
         dividend_d_ff <= dividend_ff;
         estimate_ff   <= estimate_in;
         quotient_ff   <= quotient_in;
      end
   end

endmodule

// File: design/hsv2rgb_map.sv
// ----------------------------------------------------------------------------
// HSV to RGB channel mapping
// Picks the per-sector channel order, grey override, registered result.
// ----------------------------------------------------------------------------
module hsv2rgb_map #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                enable,
   input  hsv2rgb_pkg::side_type               side,
   input  logic [CHANNEL_BITS-1:0]             value,
   input  logic [CHANNEL_BITS-1:0]             p_level,
   input  logic [CHANNEL_BITS-1:0]             q_level,
   input  logic [CHANNEL_BITS-1:0]             t_level,
   output logic [hsv2rgb_pkg::PORT_BITS-1:0]   red_ff,
   output logic [hsv2rgb_pkg::PORT_BITS-1:0]   green_ff,
   output logic [hsv2rgb_pkg::PORT_BITS-1:0]   blue_ff
);

   localparam int OW = hsv2rgb_pkg::PORT_BITS;

   logic [CHANNEL_BITS-1:0] red_c;
   logic [CHANNEL_BITS-1:0] green_c;
   logic [CHANNEL_BITS-1:0] blue_c;
   logic [OW-1:0]           red_in;
   logic [OW-1:0]           green_in;
   logic [OW-1:0]           blue_in;

   always_comb begin
      case (side.sector)
         hsv2rgb_pkg::SECTOR_0: begin
            red_c = value;   green_c = t_level; blue_c = p_level;
         end
         hsv2rgb_pkg::SECTOR_1: begin
            red_c = q_level; green_c = value;   blue_c = p_level;
         end
         hsv2rgb_pkg::SECTOR_2: begin
            red_c = p_level; green_c = value;   blue_c = t_level;
         end
         hsv2rgb_pkg::SECTOR_3: begin
            red_c = p_level; green_c = q_level; blue_c = value;
         end
         hsv2rgb_pkg::SECTOR_4: begin
            red_c = t_level; green_c = p_level; blue_c = value;
         end
         default: begin
            red_c = value;   green_c = p_level; blue_c = q_level;
         end
      endcase
      if (side.grey) begin
         red_c   = value;
         green_c = value;
         blue_c  = value;
      end
      red_in   = OW'(red_c);
      green_in = OW'(green_c);
      blue_in  = OW'(blue_c);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

endmodule

// File: design/hsv_to_rgb_converter.sv
// A request passes through the prep, scaling and map registers before its result is valid.
// Throughput: one request per cycle; all five stages hold together while the
// result register is stalled, so nothing is dropped or repeated.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-sector fixed-point HSV to 8-bit RGB, pipelined over five stages.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
   parameter int CHANNEL_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[10:0], saturation[18:11], value[26:19], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   localparam int CW     = CHANNEL_BITS;
   localparam int KW     = CHANNEL_BITS + hsv2rgb_pkg::FRAC_BITS;
   localparam int STAGES = 5;
   localparam int DELAY  = 3;

   logic                  enable;
   logic [STAGES-1:0]     valid_ff;
   logic [STAGES-1:0]     valid_in;

   hsv2rgb_pkg::side_type side_s1;
   logic [CW-1:0]         value_s1;
   logic [CW-1:0]         p_factor_s1;
   logic [KW-1:0]         q_factor_s1;
   logic [KW-1:0]         t_factor_s1;

   hsv2rgb_pkg::side_type side_ff  [DELAY];
   logic [CW-1:0]         value_ff [DELAY];

   logic [CW-1:0]         p_level;
   logic [CW-1:0]         q_level;
   logic [CW-1:0]         t_level;

   logic [hsv2rgb_pkg::PORT_BITS-1:0] red;
   logic [hsv2rgb_pkg::PORT_BITS-1:0] green;
   logic [hsv2rgb_pkg::PORT_BITS-1:0] blue;

   assign enable     = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tdata  = {blue, green, red};
   assign valid_in   = {valid_ff[STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   hsv2rgb_prep #(.CHANNEL_BITS(CHANNEL_BITS)) u_prep (
      .clock       (clock),
      .enable      (enable),
      .hue         (req_tdata[10:0]),
      .saturation  (req_tdata[18:11]),
      .value       (req_tdata[26:19]),
      .side_ff     (side_s1),
      .value_ff    (value_s1),
      .p_factor_ff (p_factor_s1),
      .q_factor_ff (q_factor_s1),
      .t_factor_ff (t_factor_s1)
   );

   // sideband delay to line up with the scaling units
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0]  <= side_s1;
         value_ff[0] <= value_s1;
         for (int i = 1; i < DELAY; i++) begin
            side_ff[i]  <= side_ff[i-1];
            value_ff[i] <= value_ff[i-1];
         end
      end
   end

   hsv2rgb_scale #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .FACTOR_BITS  (CW),
      .PRE_SHIFT    (0)
   ) u_scale_p (
      .clock       (clock),
      .enable      (enable),
      .value       (value_s1),
      .factor      (p_factor_s1),
      .quotient_ff (p_level)
   );

   hsv2rgb_scale #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .FACTOR_BITS  (KW),
      .PRE_SHIFT    (hsv2rgb_pkg::FRAC_BITS)
   ) u_scale_q (
      .clock       (clock),
      .enable      (enable),
      .value       (value_s1),
      .factor      (q_factor_s1),
      .quotient_ff (q_level)
   );

   hsv2rgb_scale #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .FACTOR_BITS  (KW),
      .PRE_SHIFT    (hsv2rgb_pkg::FRAC_BITS)
   ) u_scale_t (
      .clock       (clock),
      .enable      (enable),
      .value       (value_s1),
      .factor      (t_factor_s1),
      .quotient_ff (t_level)
   );

   hsv2rgb_map #(.CHANNEL_BITS(CHANNEL_BITS)) u_map (
      .clock    (clock),
      .enable   (enable),
      .side     (side_ff[DELAY-1]),
      .value    (value_ff[DELAY-1]),
      .p_level  (p_level),
      .q_level  (q_level),
      .t_level  (t_level),
      .red_ff   (red),
      .green_ff (green),
      .blue_ff  (blue)
   );

endmodule
